### src/hfd_pkg.sv
// ----------------------------------------------------------------------------
// hfd_pkg
// Shared types and sizes for the Huffman tree stream decoder.
// ----------------------------------------------------------------------------
package hfd_pkg;

    // Table sizes
    localparam int MAX_NODES   = 512;
    localparam int STACK_DEPTH = 256;

    localparam int NODE_AW  = $clog2(MAX_NODES);     // node index
    localparam int NODE_CW  = NODE_AW + 1;           // free-node counter, one bit wider than the node index
    localparam int STK_AW   = $clog2(STACK_DEPTH);   // stack index
    localparam int STK_CW   = STK_AW + 1;            // stack pointer, reaches STACK_DEPTH

    localparam int SYM_W    = 8;                     // leaf byte
    localparam int LBC_W    = 4;                     // leaf bit counter
    localparam int LEN_W    = 31;                    // output length / emitted count

    // Node entry: leaf flag on top, payload (leaf byte or left child) below
    localparam int ENTRY_PW = (NODE_AW > SYM_W) ? NODE_AW : SYM_W;
    localparam int ENTRY_W  = ENTRY_PW + 1;

    // Output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = OQ_AW + 1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_DECODE,
        PH_STOPPED
    } phase_t;

    typedef enum logic {
        ERR_NONE     = 1'b0,
        ERR_OVERFLOW = 1'b1
    } err_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        err_t             error_code;
    } result_t;

endpackage

### src/huffman_tree_stream_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_stream_decoder
// Rebuilds a Huffman tree from a preorder header and decodes the bit stream.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one compressed bit per word: s_tdata[0] is the bit,
//   s_tuser[0] set starts a new stream (clears the tree, bit is the first
//   header bit). Header: '1' + 8 leaf bits MSB first, or '0' for an internal
//   node whose children are filled left then right.
//   Master side gives one decoded byte per word on m_tdata, m_tlast marks the
//   final byte of output_length bytes, m_tuser flags a node table or stack
//   overflow (m_tdata zero, m_tlast set). After last or an error the block
//   drops bits until the next start word.
//   cfg_wr_en/cfg_wr_data load output_length; write it only while idle.
// Throughput: one bit per cycle while s_tready is high, in header and
//   decode alike. Each bit makes at most one node table access; during
//   decode the registered child entry read is forwarded straight into the next bit's address.
// Output: a symbol word passes the node table read register and then the output
//   queue before it shows on the master side; errors and single-leaf-tree symbols go through the queue alone.
// Stall: results go through a four-word queue; s_tready drops only when the
//   queue plus an in-flight table read could overflow it.
// Reset: aresetn low returns to idle with output_length zero. Tables need no
//   clearing pass; no entry is read before this stream writes it.
// ----------------------------------------------------------------------------
module huffman_tree_stream_decoder (
    input  logic                       aclk,
    input  logic                       aresetn,
    // stream input
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,     // [0] stream_bit, [7:1] zero
    input  logic [0:0]                 s_tuser,     // [0] start_req
    // decoded output
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,     // [7:0] symbol
    output logic                       m_tlast,     // last
    output logic [0:0]                 m_tuser,     // [0] error_code
    // configuration
    input  logic                       cfg_wr_en,
    input  logic [hfd_pkg::LEN_W-1:0]  cfg_wr_data  // output_length
);

    import hfd_pkg::*;

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    phase_t               phase_reg, phase_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [STK_CW-1:0]    sp_reg, sp_next;
    logic [NODE_CW-1:0]   nf_reg, nf_next;            // next free node
    logic [SYM_W-1:0]     shift_reg, shift_next;
    logic [LBC_W-1:0]     lbc_reg, lbc_next;          // leaf bits still to come
    logic [NODE_AW-1:0]   tgt_reg, tgt_next;          // node being filled
    logic                 tgt_pend_reg, tgt_pend_next;// target is in stack read data
    logic [NODE_AW-1:0]   cur_left_reg, cur_left_next;// left child of walk node
    logic                 rd_pend_reg, rd_pend_next;  // decode read in flight
    logic [LEN_W-1:0]     cnt_reg, cnt_next;          // emitted symbols
    logic [ENTRY_W-1:0]   root_reg, root_next;        // copy of node 0

    // ------------------------------------------------------------------
    // Memory and queue hookup
    // ------------------------------------------------------------------
    logic                 node_we, node_re;
    logic [NODE_AW-1:0]   node_waddr, node_raddr;
    logic [ENTRY_W-1:0]   node_wdata, node_rdata;
    logic                 stk_we, stk_re;
    logic [STK_AW-1:0]    stk_waddr, stk_raddr;
    logic [NODE_AW-1:0]   stk_wdata, stk_rdata;

    logic                 oq_push;
    result_t              oq_push_data, oq_head;
    logic                 oq_valid;
    logic [OQ_CW-1:0]     oq_count;

    // ------------------------------------------------------------------
    // Resolved view of the current cycle
    // ------------------------------------------------------------------
    logic                 s_fire, in_bit, in_start;
    logic                 res_emit, res_fin;
    phase_t               phase_eff, in_phase;
    logic [LEN_W-1:0]     cnt_eff, cnt_in, cnt_inc;
    logic [NODE_AW-1:0]   left_eff, tgt_eff, tgt_in;
    logic [STK_CW-1:0]    sp_in;
    logic [NODE_CW-1:0]   nf_in;
    logic [LBC_W-1:0]     lbc_in, lbc_dec;
    logic [SYM_W-1:0]     shift_in, shift_new;
    logic                 hdr, hdr_open, hdr_ovf, hdr_int, hdr_err;
    logic                 hdr_leaf_start, hdr_leaf_bit, hdr_leaf_done, hdr_end, hdr_pop;
    logic                 dec, dec_root, dec_read, root_fin;

    assign s_tready = ({1'b0, oq_count} + (OQ_CW+1)'(rd_pend_reg)) < (OQ_CW+1)'(OQ_DEPTH);
    assign s_fire   = s_tvalid && s_tready;
    assign in_bit   = s_tdata[0];
    assign in_start = s_tuser[0];

    // Finish the table read of the previous bit, then apply the new word.
    always_comb begin
        res_emit  = rd_pend_reg && node_rdata[ENTRY_W-1];
        res_fin   = res_emit &&
                    (({1'b0, cnt_reg} + (LEN_W+1)'(1)) >= {1'b0, len_reg});
        phase_eff = res_fin ? PH_STOPPED : phase_reg;
        cnt_eff   = res_emit ? cnt_reg + LEN_W'(1) : cnt_reg;
        if (!rd_pend_reg) begin
            left_eff = cur_left_reg;
        end else if (node_rdata[ENTRY_W-1]) begin
            left_eff = root_reg[NODE_AW-1:0];     // leaf hit: back to the root
        end else begin
            left_eff = node_rdata[NODE_AW-1:0];
        end
        tgt_eff   = tgt_pend_reg ? stk_rdata : tgt_reg;

        // start word clears the header state before its bit is used
        in_phase  = in_start ? PH_HEADER : phase_eff;
        sp_in     = in_start ? '0 : sp_reg;
        nf_in     = in_start ? NODE_CW'(1) : nf_reg;
        lbc_in    = in_start ? '0 : lbc_reg;
        shift_in  = in_start ? '0 : shift_reg;
        tgt_in    = in_start ? '0 : tgt_eff;
        cnt_in    = in_start ? '0 : cnt_eff;

        hdr            = s_fire && (in_phase == PH_HEADER);
        hdr_open       = hdr && (lbc_in == '0) && !in_bit;
        hdr_ovf        = ({1'b0, nf_in} + (NODE_CW+1)'(2) > (NODE_CW+1)'(MAX_NODES)) ||
                         (sp_in >= STK_CW'(STACK_DEPTH));
        hdr_int        = hdr_open && !hdr_ovf;
        hdr_err        = hdr_open && hdr_ovf;
        hdr_leaf_start = hdr && (lbc_in == '0) && in_bit;
        hdr_leaf_bit   = hdr && (lbc_in != '0);
        shift_new      = {shift_in[SYM_W-2:0], in_bit};
        lbc_dec        = lbc_in - LBC_W'(1);
        hdr_leaf_done  = hdr_leaf_bit && (lbc_dec == '0);
        hdr_end        = hdr_leaf_done && (sp_in == '0);
        hdr_pop        = hdr_leaf_done && (sp_in != '0);

        dec      = s_fire && (in_phase == PH_DECODE);
        dec_root = dec && root_reg[ENTRY_W-1];
        dec_read = dec && !root_reg[ENTRY_W-1];
        cnt_inc  = cnt_in + LEN_W'(1);
        root_fin = ({1'b0, cnt_in} + (LEN_W+1)'(1)) >= {1'b0, len_reg};
    end

    // Table accesses and result push
    always_comb begin
        node_we    = hdr_int || hdr_leaf_done;
        node_waddr = tgt_in;
        node_wdata = hdr_int ? {1'b0, ENTRY_PW'(nf_in[NODE_AW-1:0])}
                             : {1'b1, ENTRY_PW'(shift_new)};
        root_next  = (node_we && (tgt_in == '0)) ? node_wdata : root_reg;
        node_re    = dec_read;
        node_raddr = left_eff + NODE_AW'(in_bit);

        stk_we     = hdr_int;
        stk_waddr  = sp_in[STK_AW-1:0];
        stk_wdata  = nf_in[NODE_AW-1:0] + NODE_AW'(1);
        stk_re     = hdr_pop;
        stk_raddr  = stk_waddr - STK_AW'(1);

        oq_push    = res_emit || hdr_err || dec_root;
        oq_push_data.symbol     = '0;
        oq_push_data.last       = 1'b1;
        oq_push_data.error_code = ERR_OVERFLOW;
        if (res_emit) begin
            oq_push_data.symbol     = node_rdata[SYM_W-1:0];
            oq_push_data.last       = res_fin;
            oq_push_data.error_code = ERR_NONE;
        end else if (dec_root) begin
            oq_push_data.symbol     = root_reg[SYM_W-1:0];
            oq_push_data.last       = root_fin;
            oq_push_data.error_code = ERR_NONE;
        end
    end

    // Phase
    always_comb begin
        phase_next = s_fire ? in_phase : phase_eff;
        if (hdr_err) begin
            phase_next = PH_STOPPED;
        end else if (hdr_end) begin
            phase_next = (len_reg == '0) ? PH_STOPPED : PH_DECODE;
        end else if (dec_root && root_fin) begin
            phase_next = PH_STOPPED;
        end
    end

    // Datapath next values
    always_comb begin
        len_next      = cfg_wr_en ? cfg_wr_data : len_reg;
        sp_next       = s_fire ? sp_in : sp_reg;
        nf_next       = s_fire ? nf_in : nf_reg;
        lbc_next      = s_fire ? lbc_in : lbc_reg;
        shift_next    = s_fire ? shift_in : shift_reg;
        tgt_next      = s_fire ? tgt_in : tgt_eff;
        tgt_pend_next = hdr_pop;
        cur_left_next = left_eff;
        rd_pend_next  = dec_read;
        cnt_next      = s_fire ? cnt_in : cnt_eff;

        if (hdr_int) begin
            sp_next  = sp_in + STK_CW'(1);
            nf_next  = nf_in + NODE_CW'(2);
            tgt_next = nf_in[NODE_AW-1:0];
        end
        if (hdr_leaf_start) begin
            lbc_next   = LBC_W'(SYM_W);
            shift_next = '0;
        end
        if (hdr_leaf_bit) begin
            lbc_next   = lbc_dec;
            shift_next = shift_new;
        end
        if (hdr_pop) begin
            sp_next = sp_in - STK_CW'(1);
        end
        if (hdr_end) begin
            cnt_next      = '0;
            cur_left_next = root_next[NODE_AW-1:0];
        end
        if (dec_root) begin
            cnt_next = cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            len_reg      <= '0;
            sp_reg       <= '0;
            nf_reg       <= NODE_CW'(1);
            lbc_reg      <= '0;
            shift_reg    <= '0;
            tgt_reg      <= '0;
            tgt_pend_reg <= 1'b0;
            cur_left_reg <= '0;
            rd_pend_reg  <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            phase_reg    <= phase_next;
            len_reg      <= len_next;
            sp_reg       <= sp_next;
            nf_reg       <= nf_next;
            lbc_reg      <= lbc_next;
            shift_reg    <= shift_next;
            tgt_reg      <= tgt_next;
            tgt_pend_reg <= tgt_pend_next;
            cur_left_reg <= cur_left_next;
            rd_pend_reg  <= rd_pend_next;
            cnt_reg      <= cnt_next;
        end
    end

    // root copy is payload, valid once the header writes node 0
    always_ff @(posedge aclk) begin
        root_reg <= root_next;
    end

    // ------------------------------------------------------------------
    // Instances
    // ------------------------------------------------------------------
    hfd_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (ENTRY_W)
    ) u_node_ram (
        .aclk    (aclk),
        .wr_en   (node_we),
        .wr_addr (node_waddr),
        .wr_data (node_wdata),
        .rd_en   (node_re),
        .rd_addr (node_raddr),
        .rd_data (node_rdata)
    );

    hfd_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (NODE_AW)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (stk_wdata),
        .rd_en   (stk_re),
        .rd_addr (stk_raddr),
        .rd_data (stk_rdata)
    );

    hfd_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (oq_push),
        .push_data  (oq_push_data),
        .pop        (m_tready),
        .head_data  (oq_head),
        .head_valid (oq_valid),
        .count      (oq_count)
    );

    assign m_tvalid   = oq_valid;
    assign m_tdata    = oq_head.symbol;
    assign m_tlast    = oq_head.last;
    assign m_tuser[0] = oq_head.error_code;

endmodule

### src/hfd_ram.sv
// ----------------------------------------------------------------------------
// hfd_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hfd_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 10
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/hfd_out_fifo.sv
// ----------------------------------------------------------------------------
// hfd_out_fifo
// Small result queue between the decode core and the master port.
// ----------------------------------------------------------------------------
module hfd_out_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  hfd_pkg::result_t       push_data,
    input  logic                   pop,
    output hfd_pkg::result_t       head_data,
    output logic                   head_valid,
    output logic [hfd_pkg::OQ_CW-1:0] count
);

    import hfd_pkg::*;

    result_t          entries [OQ_DEPTH];
    logic [OQ_AW-1:0] head_reg, head_next;
    logic [OQ_AW-1:0] tail_reg, tail_next;
    logic [OQ_CW-1:0] count_reg, count_next;
    logic             do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign head_valid = (count_reg != '0);
    assign head_data  = entries[head_reg];
    assign count      = count_reg;

    always_comb begin
        head_next  = do_pop ? head_reg + OQ_AW'(1) : head_reg;
        tail_next  = push ? tail_reg + OQ_AW'(1) : tail_reg;
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + OQ_CW'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - OQ_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[tail_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

### test/hfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfd_checker
// Predicts and checks the output words of the Huffman tree stream decoder.
// ----------------------------------------------------------------------------
// Rebuilds the tree and walks it for every bit word taken on the slave side,
// queues the word the decoder should send, and compares each master-side word
// field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module hfd_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [7:0]                s_tdata,     // [0] stream_bit, [7:1] zero
    input  logic [0:0]                s_tuser,     // [0] start_req
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [7:0]                m_tdata,     // [7:0] symbol
    input  logic                      m_tlast,     // last
    input  logic [0:0]                m_tuser,     // [0] error_code
    input  logic                      cfg_wr_en,
    input  logic [hfd_pkg::LEN_W-1:0] cfg_wr_data, // output_length
    output int                        mismatches,
    output int                        outstanding,
    output int                        live_bits
);
    import hfd_pkg::*;

    localparam logic [ENTRY_W-1:0] LEAF_MARK = ENTRY_W'(1) << ENTRY_PW;

    // predictor state
    logic [LEN_W-1:0]   out_len;
    phase_t             ph;
    logic [ENTRY_W-1:0] node_tbl [MAX_NODES];
    logic [NODE_AW-1:0] right_stk [STACK_DEPTH];
    logic [STK_CW-1:0]  sp;
    logic [NODE_CW-1:0] free_node;
    logic [SYM_W-1:0]   leaf_acc;
    logic [LBC_W-1:0]   leaf_left;
    logic [NODE_AW-1:0] leaf_dst;
    logic [NODE_AW-1:0] walk_pos;
    logic [LEN_W-1:0]   sym_count;

    result_t decoded_q [$];
    int      fails    = 0;
    int      live_cnt = 0;
    int      word_idx = 0;

    task automatic emit_sym(input logic [SYM_W-1:0] v);
        result_t r;
        r.symbol     = v;
        r.last       = (({1'b0, sym_count} + 32'd1) >= {1'b0, out_len});
        r.error_code = ERR_NONE;
        sym_count    = sym_count + LEN_W'(1);
        if (r.last) ph = PH_STOPPED;
        decoded_q.push_back(r);
    endtask

    task automatic walk_bit(input logic b, input logic st);
        logic [ENTRY_W-1:0] ent;
        logic [ENTRY_W-1:0] sub;
        result_t            err;
        int                 child;
        if (st) begin
            ph        = PH_HEADER;
            sp        = '0;
            free_node = NODE_CW'(1);
            leaf_acc  = '0;
            leaf_left = '0;
            leaf_dst  = '0;
            walk_pos  = '0;
            sym_count = '0;
        end
        if (ph == PH_HEADER || ph == PH_DECODE) live_cnt++;
        if (ph == PH_HEADER) begin
            if (leaf_left == 0) begin
                if (b) begin
                    leaf_left = LBC_W'(SYM_W);
                    leaf_acc  = '0;
                end else if (int'(free_node) + 2 > MAX_NODES || int'(sp) >= STACK_DEPTH) begin
                    // no room for two more children or a stack entry: error word, block halts
                    ph             = PH_STOPPED;
                    err.symbol     = '0;
                    err.last       = 1'b1;
                    err.error_code = ERR_OVERFLOW;
                    decoded_q.push_back(err);
                end else begin
                    node_tbl[leaf_dst]       = ENTRY_W'(free_node);
                    right_stk[sp[STK_AW-1:0]] = NODE_AW'(free_node + NODE_CW'(1));
                    sp        = sp + STK_CW'(1);
                    leaf_dst  = NODE_AW'(free_node);
                    free_node = free_node + NODE_CW'(2);
                end
            end else begin
                leaf_acc  = {leaf_acc[SYM_W-2:0], b};
                leaf_left = leaf_left - LBC_W'(1);
                if (leaf_left == 0) begin
                    node_tbl[leaf_dst] = ENTRY_W'(leaf_acc) | LEAF_MARK;
                    if (sp == 0) begin
                        walk_pos  = '0;
                        sym_count = '0;
                        ph        = (out_len == 0) ? PH_STOPPED : PH_DECODE;
                    end else begin
                        sp       = sp - STK_CW'(1);
                        leaf_dst = right_stk[sp[STK_AW-1:0]];
                    end
                end
            end
        end else if (ph == PH_DECODE) begin
            ent = node_tbl[0];
            if (ent[ENTRY_PW]) begin
                // single-leaf tree: bit unused
                emit_sym(ent[SYM_W-1:0]);
            end else begin
                ent   = node_tbl[walk_pos];
                child = int'(ent[ENTRY_PW-1:0]) + int'(b);
                sub   = (child < MAX_NODES) ? node_tbl[child] : '0;
                if (sub[ENTRY_PW]) begin
                    walk_pos = '0;
                    emit_sym(sub[SYM_W-1:0]);
                end else begin
                    walk_pos = (child < MAX_NODES) ? NODE_AW'(child) : '0;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            out_len   = '0;
            ph        = PH_IDLE;
            sp        = '0;
            free_node = NODE_CW'(1);
            leaf_acc  = '0;
            leaf_left = '0;
            leaf_dst  = '0;
            walk_pos  = '0;
            sym_count = '0;
            decoded_q.delete();
        end else begin
            if (cfg_wr_en) out_len = cfg_wr_data;
            if (s_tvalid && s_tready) walk_bit(s_tdata[0], s_tuser[0]);
            if (m_tvalid && m_tready) begin
                got.symbol     = m_tdata;
                got.last       = m_tlast;
                got.error_code = err_t'(m_tuser[0]);
                if (decoded_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display(
                            "hfd_checker: unexpected word %0d symbol %02h last %0b error %0b",
                            word_idx, got.symbol, got.last, got.error_code);
                end else begin
                    want = decoded_q.pop_front();
                    if (got.symbol !== want.symbol || got.last !== want.last ||
                        got.error_code !== want.error_code) begin
                        fails++;
                        if (fails <= 10)
                            $display(
                                "hfd_checker: word %0d exp/got sym %02h/%02h last %0b/%0b err %0b/%0b",
                                word_idx, want.symbol, got.symbol, want.last,
                                got.last, want.error_code, got.error_code);
                    end
                end
                word_idx++;
            end
        end
        mismatches  <= fails;
        outstanding <= decoded_q.size();
        live_bits   <= live_cnt;
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the Huffman tree stream decoder.
// ----------------------------------------------------------------------------
// Feeds preorder tree headers followed by coded bits, one bit per word, across
// rounds that each load a new output length after the last round drains. Both
// channels idle and stall at random; hfd_checker predicts and compares the
// decoded words and reports its failure count back here.
// ----------------------------------------------------------------------------
module tb_top;
    import hfd_pkg::*;

    localparam int LIVE_TARGET = 1450;   // bit words that reach header or decode
    localparam int QUIET_LIMIT = 4000;   // cycles with no word moving on either side
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int SETTLE      = 6;      // margin for the decoder's registered table read and output queue

    typedef enum logic [2:0] {
        SK_TREE,      // random tree, then coded bits
        SK_SINGLE,    // one-leaf tree, then bits that are not used
        SK_HOLD,      // one-leaf tree under a long receiver hold-off
        SK_CUT,       // header abandoned part way by the next start
        SK_NOISE,     // raw bits, starts sprinkled in
        SK_OVERFLOW   // left chain one node longer than the table allows
    } stream_kind_t;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata     = '0;    // [0] stream_bit, [7:1] zero
    logic [0:0]       s_tuser     = '0;    // [0] start_req
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [7:0]       m_tdata;             // [7:0] symbol
    logic             m_tlast;
    logic [0:0]       m_tuser;             // [0] error_code
    logic             cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0] cfg_wr_data = '0;

    int mismatches;
    int outstanding;
    int live_bits;
    int hold_reqs = 0;    // bumped to ask the receiver for a long hold-off
    bit tx_quiet  = 1'b0; // sender runs without gaps while set

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    huffman_tree_stream_decoder uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    hfd_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .live_bits   (live_bits)
    );

    // Sender gap: mostly none, some short, a few long.
    function automatic int tx_gap();
        int r;
        if (tx_quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 75) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // One bit word. Called at a clock edge, returns at the edge that took it,
    // leaving tvalid high so back-to-back words never lower it in between.
    task automatic put_bit(input logic b, input logic st);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, b};
        s_tuser  <= st;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic put_byte(input logic [7:0] v);
        for (int k = 7; k >= 0; k--) put_bit(v[k], 1'b0);
    endtask

    task automatic put_coded(input int n);
        for (int i = 0; i < n; i++) put_bit(1'($urandom_range(0, 1)), 1'b0);
    endtask

    // Preorder header of a random full tree with n_int internal nodes. The
    // open-slot count stands in for recursion: an internal node opens one more
    // slot, a leaf fills one. A cut >= 0 abandons the header after that many bits.
    task automatic put_tree(input int n_int, input int cut);
        int         slots;
        int         made;
        int         sent;
        logic [7:0] v;
        slots = 1;
        made  = 0;
        sent  = 0;
        while (slots > 0 && sent != cut) begin
            if (made < n_int && (slots == 1 || $urandom_range(0, 2) != 0)) begin
                put_bit(1'b0, sent == 0);
                sent++;
                made++;
                slots++;
            end else begin
                case ($urandom_range(0, 5))
                    0:       v = 8'h00;
                    1:       v = 8'hFF;
                    default: v = 8'($urandom_range(0, 255));
                endcase
                put_bit(1'b1, sent == 0);
                sent++;
                for (int k = 7; k >= 0 && sent != cut; k--) begin
                    put_bit(v[k], 1'b0);
                    sent++;
                end
                slots--;
            end
        end
    endtask

    task automatic send_stream(input stream_kind_t kind);
        case (kind)
            SK_TREE: begin
                // mostly shallow trees, now and then a bushier one
                if ($urandom_range(0, 4) == 0) put_tree($urandom_range(13, 40), -1);
                else put_tree($urandom_range(1, 12), -1);
                put_coded($urandom_range(0, 40));
            end
            SK_SINGLE: begin
                put_tree(0, -1);
                put_coded($urandom_range(0, 12));
            end
            SK_HOLD: begin
                // every bit makes a word here, so the output queue fills and
                // s_tready must drop while the receiver holds off
                put_tree(0, -1);
                hold_reqs++;
                put_coded(40);
            end
            SK_CUT: begin
                put_tree($urandom_range(2, 10), $urandom_range(1, 30));
            end
            SK_NOISE: begin
                for (int i = $urandom_range(8, 24); i > 0; i--)
                    put_bit(1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0);
            end
            SK_OVERFLOW: begin
                // 255 zeros use slots up to 510; the 256th has no room left
                for (int i = 0; i < 256; i++) put_bit(1'b0, i == 0);
                put_coded($urandom_range(0, 6));
            end
            default: ;
        endcase
    endtask

    function automatic stream_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 59);
        if (r == 0) return SK_OVERFLOW;
        if (r < 6) return SK_NOISE;
        if (r < 12) return SK_CUT;
        if (r < 19) return SK_SINGLE;
        return SK_TREE;
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LEN_W'(1);
            2:       return '1;
            3:       return LEN_W'($urandom);
            default: return LEN_W'($urandom_range(2, 24));
        endcase
    endfunction

    // Stop sending, wait for every predicted word, then let the pipeline
    // settle so a bit that gives no word is surely through too.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_len(input logic [LEN_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Receiver: random ready with short and long stalls, stretches of steady
    // ready, and a long hold-off whenever the sender asks for one.
    initial begin : rx_side
        int stall;
        int seen;
        int span;
        int r;
        bit quiet;
        stall = 0;
        seen  = 0;
        span  = 0;
        quiet = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_reqs != seen) begin
                seen  = hold_reqs;
                stall = HOLD_CYCLES;
            end
            if (span == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
                span  = $urandom_range(50, 300);
            end
            span--;
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                end
            end
        end
    end

    // Watchdog: a run where no word moves for too long has hung.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin : stimulus
        int               round;
        int               n_streams;
        logic [LEN_W-1:0] len;
        stream_kind_t     kind;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: a bit before any start is dropped; a two-leaf tree with
        // the extreme byte values; the word after the last symbol is dropped.
        write_len(LEN_W'(2));
        put_bit(1'b1, 1'b0);
        put_bit(1'b0, 1'b1);          // root is internal
        put_bit(1'b1, 1'b0);          // left leaf 0x00
        put_byte(8'h00);
        put_bit(1'b1, 1'b0);          // right leaf 0xFF
        put_byte(8'hFF);
        put_bit(1'b1, 1'b0);          // 0xFF
        put_bit(1'b0, 1'b0);          // 0x00, last
        put_bit(1'b1, 1'b0);          // stopped: dropped
        drain();

        // Random rounds. The first few pin down cases worth seeing every run:
        // round 0 leaves a stream decoding under the largest length, round 1
        // lowers it to one while that stream goes on, round 2 has zero length,
        // round 3 overflows the node table, round 4 holds off the receiver.
        round = 0;
        while (live_bits < LIVE_TARGET) begin
            case (round)
                0:       len = '1;
                1:       len = LEN_W'(1);
                2:       len = '0;
                3:       len = LEN_W'($urandom_range(2, 24));
                4:       len = '1;
                default: len = pick_len();
            endcase
            write_len(len);
            // carry on with the stream from before the write, no new start
            if (round == 1 || $urandom_range(0, 2) == 0) put_coded($urandom_range(1, 12));
            n_streams = $urandom_range(1, 4);
            for (int s = 0; s < n_streams; s++) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                if (round == 0) kind = SK_TREE;
                else if (round == 3 && s == 0) kind = SK_OVERFLOW;
                else if (round == 4 && s == 0) kind = SK_HOLD;
                else kind = pick_kind();
                send_stream(kind);
            end
            drain();
            round++;
        end

        repeat (4 * SETTLE) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
